// ===== design/wsd_pkg.sv =====
// Package for the WebSocket frame deframer: parser phases, frame kind codes
// and the result word passed from the parser to the output stage.
// No dependencies.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_t;

  localparam logic [2:0] KIND_TEXT        = 3'd0;
  localparam logic [2:0] KIND_TEXT_PART   = 3'd1;
  localparam logic [2:0] KIND_BINARY      = 3'd2;
  localparam logic [2:0] KIND_BINARY_PART = 3'd3;
  localparam logic [2:0] KIND_PING        = 3'd4;
  localparam logic [2:0] KIND_PONG        = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN     = 3'd6;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN7_MAX   = 7'd125;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1024;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [2:0] frame_kind;
    logic       last_of_frame;
    logic       too_long;
  } res_t;

endpackage

// ===== design/wsd_in_stage.sv =====
// Input register of the deframer: holds one incoming word until the parser
// consumes it. Depends on nothing but clk and rst_n.
module wsd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       byte_v,
  output logic [7:0] byte_q
);

  logic       v_r, v_nxt;
  logic [7:0] byte_r;

  assign in_ready = !v_r || take;
  assign byte_v   = v_r;
  assign byte_q   = byte_r;

  always_comb begin
    v_nxt = v_r;
    if (in_valid && in_ready) begin
      v_nxt = 1'b1;
    end else if (take) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

// ===== design/wsd_parser.sv =====
// Frame header parser and unmasking datapath of the deframer.
// Uses wsd_pkg for phases, kind codes and the result word.
module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_v,
  input  logic [7:0]  byte_q,
  input  logic        res_free,
  input  logic [31:0] max_payload,
  output logic        take,
  output res_t        res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r, fin_nxt;
  logic        masked_r, masked_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [2:0]  key_left_r, key_left_nxt;
  logic [63:0] left_r, left_nxt;
  logic [1:0]  kidx_r, kidx_nxt;

  logic [6:0]  len7;
  logic [63:0] len_ext;
  logic [63:0] left_dec;
  logic        gives;
  logic [7:0]  key_byte;
  logic [2:0]  kind;

  assign len7     = byte_q[6:0];
  assign len_ext  = {len_r[55:0], byte_q};
  assign left_dec = left_r - 64'd1;
  assign take     = byte_v && (!gives || res_free);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      unique case (phase_r)
        PH_HDR0: phase_nxt = PH_HDR1;
        PH_HDR1: begin
          if (len7 > LEN7_MAX) begin
            phase_nxt = PH_EXT;
          end else if (byte_q[7]) begin
            phase_nxt = PH_KEY;
          end else begin
            phase_nxt = (len7 == 7'd0) ? PH_HDR0 : PH_DATA;
          end
        end
        PH_EXT: begin
          if (ext_left_r == 4'd1) begin
            if (masked_r) begin
              phase_nxt = PH_KEY;
            end else begin
              phase_nxt = (len_ext == 64'd0) ? PH_HDR0 : PH_DATA;
            end
          end
        end
        PH_KEY: begin
          if (key_left_r == 3'd1) begin
            phase_nxt = (len_r == 64'd0) ? PH_HDR0 : PH_DATA;
          end
        end
        PH_DATA: phase_nxt = (left_dec == 64'd0) ? PH_HDR0 : PH_DATA;
        default: phase_nxt = PH_HDR0;
      endcase
    end
  end

  always_comb begin
    unique case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    priority if (opcode_r == OP_CONT || opcode_r == OP_TEXT) begin
      kind = fin_r ? KIND_TEXT : KIND_TEXT_PART;
    end else if (opcode_r == OP_BINARY) begin
      kind = fin_r ? KIND_BINARY : KIND_BINARY_PART;
    end else if (opcode_r == OP_PING) begin
      kind = KIND_PING;
    end else if (opcode_r == OP_PONG) begin
      kind = KIND_PONG;
    end else begin
      kind = KIND_UNKNOWN;
    end
  end

  // Datapath and result
  always_comb begin
    opcode_nxt   = opcode_r;
    fin_nxt      = fin_r;
    masked_nxt   = masked_r;
    ext_left_nxt = ext_left_r;
    len_nxt      = len_r;
    key_nxt      = key_r;
    key_left_nxt = key_left_r;
    left_nxt     = left_r;
    kidx_nxt     = kidx_r;
    gives        = 1'b0;
    res          = '0;
    unique case (phase_r)
      PH_HDR0: begin
        opcode_nxt = byte_q[3:0];
        fin_nxt    = byte_q[7];
      end
      PH_HDR1: begin
        masked_nxt = byte_q[7];
        len_nxt    = '0;
        if (len7 > LEN7_MAX) begin
          ext_left_nxt = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
        end else begin
          len_nxt = {57'd0, len7};
          if (byte_q[7]) begin
            key_nxt      = '0;
            key_left_nxt = KEY_BYTES;
          end else begin
            kidx_nxt = '0;
            left_nxt = {57'd0, len7};
            gives    = (len7 == 7'd0);
          end
        end
      end
      PH_EXT: begin
        len_nxt      = len_ext;
        ext_left_nxt = ext_left_r - 4'd1;
        if (ext_left_r == 4'd1) begin
          if (masked_r) begin
            key_nxt      = '0;
            key_left_nxt = KEY_BYTES;
          end else begin
            kidx_nxt = '0;
            left_nxt = len_ext;
            gives    = (len_ext == 64'd0);
          end
        end
      end
      PH_KEY: begin
        key_nxt      = {key_r[23:0], byte_q};
        key_left_nxt = key_left_r - 3'd1;
        if (key_left_r == 3'd1) begin
          kidx_nxt = '0;
          left_nxt = len_r;
          gives    = (len_r == 64'd0);
        end
      end
      PH_DATA: begin
        kidx_nxt = kidx_r + 2'd1;
        left_nxt = left_dec;
        gives    = 1'b1;
      end
      default: ;
    endcase

    res.valid      = take && gives;
    res.frame_kind = kind;
    res.too_long   = (len_nxt[63:32] != 32'd0) || (len_nxt[31:0] > max_payload);
    if (phase_r == PH_DATA) begin
      res.payload_byte  = masked_r ? (byte_q ^ key_byte) : byte_q;
      res.has_byte      = 1'b1;
      res.last_of_frame = (left_dec == 64'd0);
    end else begin
      res.last_of_frame = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      opcode_r   <= '0;
      fin_r      <= 1'b0;
      masked_r   <= 1'b0;
      ext_left_r <= '0;
      len_r      <= '0;
      key_r      <= '0;
      key_left_r <= '0;
      left_r     <= '0;
      kidx_r     <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (take) begin
        opcode_r   <= opcode_nxt;
        fin_r      <= fin_nxt;
        masked_r   <= masked_nxt;
        ext_left_r <= ext_left_nxt;
        len_r      <= len_nxt;
        key_r      <= key_nxt;
        key_left_r <= key_left_nxt;
        left_r     <= left_nxt;
        kidx_r     <= kidx_nxt;
      end
    end
  end

endmodule

// ===== design/wsd_out_stage.sv =====
// Result register of the deframer: holds one result word until taken.
// Uses wsd_pkg for the result word.
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       res,
  output logic       res_free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_has_byte,
  output logic [2:0] out_frame_kind,
  output logic       out_last_of_frame,
  output logic       out_too_long
);

  logic valid_r, valid_nxt;
  res_t data_r;

  assign res_free  = !valid_r || out_ready;
  assign out_valid = valid_r;

  assign out_payload_byte  = data_r.payload_byte;
  assign out_has_byte      = data_r.has_byte;
  assign out_frame_kind    = data_r.frame_kind;
  assign out_last_of_frame = data_r.last_of_frame;
  assign out_too_long      = data_r.too_long;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data_r <= res;
    end
  end

endmodule

// ===== design/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: input register, header parser
// with unmasking, result register and the max_payload register. Uses wsd_pkg.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------
//  input   | in_byte                                 | in_valid/in_ready
//  result  | out_payload_byte, out_has_byte,         | out_valid/out_ready
//          | out_frame_kind, out_last_of_frame,      |
//          | out_too_long                            |
//  config  | cfg_wdata (max_payload)                 | cfg_we
//
// One word per cycle while the parser is not stalled; the accepting edge loads a
// word into the input register, and the edge on which the parser takes it moves
// the parser's result for that word into the result register.
// Header, length and key words give no result unless they end an empty frame.
// A full result register stalls the parser only on words that give a result.
// Synchronous reset clears all control state and sets max_payload to 1024.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_has_byte,
  output logic [2:0]  out_frame_kind,
  output logic        out_last_of_frame,
  output logic        out_too_long,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0] max_payload_r;
  logic        byte_v;
  logic [7:0]  byte_q;
  logic        take;
  logic        res_free;
  res_t        res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

  wsd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .take     (take),
    .byte_v   (byte_v),
    .byte_q   (byte_q)
  );

  wsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_v      (byte_v),
    .byte_q      (byte_q),
    .res_free    (res_free),
    .max_payload (max_payload_r),
    .take        (take),
    .res         (res)
  );

  wsd_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res               (res),
    .res_free          (res_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_has_byte      (out_has_byte),
    .out_frame_kind    (out_frame_kind),
    .out_last_of_frame (out_last_of_frame),
    .out_too_long      (out_too_long)
  );

  a_res_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> take)
    else $error("result produced without consuming a word");

  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> out_valid)
    else $error("result not held in output register");

  a_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> byte_v)
    else $error("accepted word missing from input register");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (byte_v && !take && !res_free))
    else $error("input stalled without a blocked result");

endmodule
